// ===== rtl/mwg_pkg.sv =====
// ============================================================================
// mwg_pkg
// Shared types, constants and the quarter-wave sine table builder for the
// multi-waveform generator.
// ============================================================================
`default_nettype none

package mwg_pkg;

  localparam int TABLE_ADDR_BITS = 10;
  localparam int PHASE_BITS      = 32;
  localparam int TABLE_SIZE      = 1 << TABLE_ADDR_BITS;
  localparam int MAG_BITS        = 15;
  localparam int SAMPLE_BITS     = 16;
  localparam int CFG_ADDR_BITS   = 3;
  localparam int CFG_DATA_BITS   = 32;

  localparam logic signed [SAMPLE_BITS-1:0] PEAK     = 16'sd32760;
  localparam logic signed [SAMPLE_BITS-1:0] NEG_PEAK = -16'sd32760;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [MAG_BITS-1:0]           mag_t;
  typedef logic [TABLE_ADDR_BITS-1:0]    tab_addr_t;
  typedef logic [PHASE_BITS-1:0]         phase_t;
  typedef mag_t                          sine_rom_t [TABLE_SIZE];

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_SAWTOOTH = 2'd2,
    WAVE_TRIANGLE = 2'd3
  } wave_kind_t;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_WAVE_KIND      = 3'd0,
    REG_PHASE_STEP     = 3'd1,
    REG_PERIOD_SAMPLES = 3'd2,
    REG_SAW_STEP       = 3'd3,
    REG_TRI_STEP       = 3'd4
  } cfg_reg_t;

  // Values the generator core presents for the sample it is about to emit.
  typedef struct packed {
    tab_addr_t rom_addr;   // table index, already mirrored for odd quadrants
    logic      peak_sel;   // odd quadrant at index zero: magnitude is the peak
    logic      negate;     // lower half-cycle of the sine
    sample_t   alt_sample; // square, sawtooth or triangle value
  } gen_view_t;

  // Unsigned 64-bit quotient by shift and subtract; only used while the
  // table is built at elaboration.
  function automatic longint unsigned udiv64(longint unsigned num,
                                             longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave table, evaluated at elaboration by a fixed-point Taylor series.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t         tab;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint unsigned   den;
    longint            sum;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      x    = (HALF_PI_Q30 * longint'(k)) >> TABLE_ADDR_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n < 40; n++) begin
        if (term != 0) begin
          den  = longint'((2 * n) * (2 * n + 1));
          term = udiv64((term * x2) >> 30, den);
          if (n[0]) begin
            sum = sum - longint'(term);
          end else begin
            sum = sum + longint'(term);
          end
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      tab[k] = MAG_BITS'(($unsigned(sum) * 64'd32760) >> 30);
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mwg_if.sv =====
// ============================================================================
// mwg_if
// Valid/ready channel interfaces for the input items and the output samples.
// ============================================================================
`default_nettype none

interface mwg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface mwg_out_if import mwg_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/mwg_sine_rom.sv =====
// ============================================================================
// mwg_sine_rom
// Quarter-wave sine table with a registered read port.
// ============================================================================
`default_nettype none

module mwg_sine_rom import mwg_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rd_en,
  input  wire tab_addr_t rd_addr,
  output mag_t           rd_data
);

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  mag_t rd_data_r;

  // Data holds while no read is issued, so a stalled consumer keeps it.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= SINE_ROM[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/mwg_gen_core.sv =====
// ============================================================================
// mwg_gen_core
// Phase accumulator, sawtooth ramp and triangle generator state with their
// per-sample update.
// ============================================================================
`default_nettype none

module mwg_gen_core import mwg_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   advance,
  input  wire logic                   restart,
  input  wire wave_kind_t             wave_kind,
  input  wire logic [31:0]            phase_step,
  input  wire logic [15:0]            period_samples,
  input  wire logic [MAG_BITS-1:0]    saw_step,
  input  wire logic [MAG_BITS-1:0]    tri_step,
  output gen_view_t                   view
);

  localparam phase_t PHASE_HALF = phase_t'(1) << (PHASE_BITS - 1);

  phase_t      phase_r,      phase_nxt;
  sample_t     ramp_value_r, ramp_value_nxt;
  logic [15:0] ramp_count_r, ramp_count_nxt;
  sample_t     tri_value_r,  tri_value_nxt;
  logic        tri_rising_r, tri_rising_nxt;

  // State as seen by this sample, after an optional restart.
  phase_t      phase_cur;
  sample_t     ramp_cur;
  logic [15:0] count_cur;
  sample_t     tri_cur;
  logic        rising_cur;

  logic [1:0]        quad;
  tab_addr_t         idx;
  sample_t           square_val;
  logic [16:0]       count_inc;
  logic signed [17:0] tri_d;
  logic signed [17:0] tri_sum;
  logic signed [17:0] fold_t;

  always_comb begin
    phase_cur  = restart ? '0 : phase_r;
    ramp_cur   = restart ? NEG_PEAK : ramp_value_r;
    count_cur  = restart ? '0 : ramp_count_r;
    tri_cur    = restart ? NEG_PEAK : tri_value_r;
    rising_cur = restart ? 1'b0 : tri_rising_r;
  end

  // Sine addressing and square wave.
  always_comb begin
    quad = phase_cur[PHASE_BITS-1 -: 2];
    idx  = phase_cur[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    if (phase_cur == '0 || phase_cur == PHASE_HALF) begin
      square_val = '0;
    end else if (!phase_cur[PHASE_BITS-1]) begin
      square_val = PEAK;
    end else begin
      square_val = NEG_PEAK;
    end
  end

  always_comb begin
    view.rom_addr = quad[0] ? tab_addr_t'(-idx) : idx;
    view.peak_sel = quad[0] && (idx == '0);
    view.negate   = quad[1];
    unique case (wave_kind)
      WAVE_SQUARE:   view.alt_sample = square_val;
      WAVE_SAWTOOTH: view.alt_sample = ramp_cur;
      WAVE_TRIANGLE: view.alt_sample = tri_cur;
      default:       view.alt_sample = '0;
    endcase
  end

  // Next state.
  always_comb begin
    phase_nxt = phase_cur + phase_t'(phase_step);

    count_inc = {1'b0, count_cur} + 17'd1;
    if (count_inc >= {1'b0, period_samples}) begin
      ramp_count_nxt = '0;
      ramp_value_nxt = NEG_PEAK;
    end else begin
      ramp_count_nxt = count_inc[15:0];
      ramp_value_nxt = ramp_cur + sample_t'({1'b0, saw_step});
    end

    tri_d   = rising_cur ? 18'sd0 + 18'($unsigned(tri_step))
                         : 18'sd0 - 18'($unsigned(tri_step));
    tri_sum = 18'(tri_cur) + tri_d;
    fold_t  = '0;
    tri_rising_nxt = rising_cur;
    if (tri_sum >= 18'sd32760 || tri_sum <= -18'sd32760) begin
      if (tri_cur < 0) begin
        fold_t        = tri_sum + 18'sd32760;
        tri_value_nxt = sample_t'(-18'sd32760 - fold_t);
      end else begin
        fold_t        = tri_sum - 18'sd32760;
        tri_value_nxt = sample_t'(18'sd32760 - fold_t);
      end
      tri_rising_nxt = !rising_cur;
    end else begin
      tri_value_nxt = sample_t'(tri_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= '0;
      ramp_value_r <= NEG_PEAK;
      ramp_count_r <= '0;
      tri_value_r  <= NEG_PEAK;
      tri_rising_r <= 1'b0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      ramp_value_r <= ramp_value_nxt;
      ramp_count_r <= ramp_count_nxt;
      tri_value_r  <= tri_value_nxt;
      tri_rising_r <= tri_rising_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/multi_waveform_generator_top.sv =====
// ============================================================================
// multi_waveform_generator_top
// Direct digital synthesis source of sine, square, sawtooth and triangle
// samples, one signed 16-bit sample per transfer on the input channel.
// ============================================================================
//
//   Channel   Direction  Payload        Transfer condition
//   in_ch     sink       restart        in_ch.valid && in_ch.ready
//   out_ch    source     sample (s16)   out_ch.valid && out_ch.ready
//   cfg_*     write      index, data    cfg_we high at a clock edge
//
// Each input transfer yields one sample: stage 1 issues the quarter-wave
// table read and registers the generator view, then the output stage forms
// the signed sine value and selects the waveform into the output register.
// One item is taken every cycle while out_ch.ready stays high.
// Reset (rst_n low, synchronous) clears the generators and the registers to
// their documented defaults; the table is a constant and needs no fill.
// When out_ch.ready stays low the pipeline holds both stages and then drops
// in_ch.ready; a sample in the output register never blocks the stage behind
// it from being taken in the same cycle the register empties.
// ============================================================================
`default_nettype none

module multi_waveform_generator_top import mwg_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  mwg_in_if.sink                        in_ch,
  mwg_out_if.source                     out_ch,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  // Configuration registers.
  wave_kind_t          wave_kind_r;
  logic [31:0]         phase_step_r;
  logic [15:0]         period_samples_r;
  logic [MAG_BITS-1:0] saw_step_r;
  logic [MAG_BITS-1:0] tri_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_kind_r      <= WAVE_SINE;
      phase_step_r     <= '0;
      period_samples_r <= 16'd100;
      saw_step_r       <= 15'd655;
      tri_step_r       <= 15'd1310;
    end else if (cfg_we) begin
      // Indexes past the last register are ignored.
      unique case (cfg_addr)
        REG_WAVE_KIND:      wave_kind_r      <= wave_kind_t'(cfg_wdata[1:0]);
        REG_PHASE_STEP:     phase_step_r     <= cfg_wdata[31:0];
        REG_PERIOD_SAMPLES: period_samples_r <= cfg_wdata[15:0];
        REG_SAW_STEP:       saw_step_r       <= cfg_wdata[MAG_BITS-1:0];
        REG_TRI_STEP:       tri_step_r       <= cfg_wdata[MAG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake. Stage 1 waits on the table read; the output register
  // presents the finished sample.
  logic      in_xfer;
  logic      s1_adv;
  logic      s1_valid_r, s1_valid_nxt;
  logic      out_valid_r, out_valid_nxt;
  sample_t   out_sample_r;

  logic      s1_is_sine_r;
  logic      s1_peak_sel_r;
  logic      s1_negate_r;
  sample_t   s1_alt_r;

  gen_view_t view;
  mag_t      rom_data;
  sample_t   sine_mag;
  sample_t   s1_sample;

  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  mwg_gen_core u_gen (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (in_xfer),
    .restart        (in_ch.restart),
    .wave_kind      (wave_kind_r),
    .phase_step     (phase_step_r),
    .period_samples (period_samples_r),
    .saw_step       (saw_step_r),
    .tri_step       (tri_step_r),
    .view           (view)
  );

  mwg_sine_rom u_rom (
    .clk     (clk),
    .rd_en   (in_xfer),
    .rd_addr (view.rom_addr),
    .rd_data (rom_data)
  );

  always_comb begin
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (s1_valid_r && s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_is_sine_r  <= (wave_kind_r == WAVE_SINE);
      s1_peak_sel_r <= view.peak_sel;
      s1_negate_r   <= view.negate;
      s1_alt_r      <= view.alt_sample;
    end
  end

  // Sine magnitude from the table, with the odd-quadrant peak substituted.
  always_comb begin
    sine_mag  = s1_peak_sel_r ? PEAK : sample_t'({1'b0, rom_data});
    s1_sample = s1_is_sine_r ? (s1_negate_r ? -sine_mag : sine_mag) : s1_alt_r;
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      out_sample_r <= s1_sample;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.sample = out_sample_r;

  // A stalled stage 1 keeps its item and its table data.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(rom_data))
    else $error("stage 1 lost its item or table data during a stall");

  // Every accepted item reaches stage 1.
  a_in_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_valid_r)
    else $error("accepted item did not enter stage 1");

  // The output register empties when it is taken and nothing follows.
  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !s1_valid_r |=> !out_ch.valid)
    else $error("output register showed a sample twice");

endmodule

`default_nettype wire
